// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the butterfly tile transform.
// Depends on nothing; the including module supplies i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// checked only out of reset
`define BTTU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define BTTU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define BTTU_ASSERT(lbl, prop, msg)
`define BTTU_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/core/bttu_pkg.sv =====
// Shared types, codes and fixed-point helpers of the butterfly tile transform.
// Depends on nothing.
package bttu_pkg;

    localparam int DW   = 32;   // Q4.27 word
    localparam int FRAC = 27;
    localparam int XW   = 17;   // raw vector address before wrap
    localparam int NTILE = 4;

    // request codes
    localparam logic [1:0] F_WR_TILE = 2'd0;
    localparam logic [1:0] F_WR_VEC  = 2'd1;
    localparam logic [1:0] F_COMP    = 2'd2;

    // kernel codes
    localparam logic [2:0] K_TL  = 3'd0;
    localparam logic [2:0] K_BL  = 3'd1;
    localparam logic [2:0] K_TR  = 3'd2;
    localparam logic [2:0] K_TRT = 3'd3;
    localparam logic [2:0] K_BR  = 3'd4;
    localparam logic [2:0] K_TOP = 3'd5;
    localparam logic [2:0] K_BTM = 3'd6;

    // register indexes
    localparam logic [2:0] R_KERNEL = 3'd0;
    localparam logic [2:0] R_LEVEL  = 3'd1;
    localparam logic [2:0] R_SIZE_N = 3'd2;
    localparam logic [2:0] R_ROWSEG = 3'd3;
    localparam logic [2:0] R_COLSEG = 3'd4;
    localparam logic [2:0] R_HERM   = 3'd5;
    localparam logic [2:0] R_DIAG   = 3'd6;
    localparam logic [2:0] R_CONJ   = 3'd7;

    // datapath modes
    localparam logic [1:0] M_TWO   = 2'd0;
    localparam logic [1:0] M_TRANS = 2'd1;
    localparam logic [1:0] M_PLAIN = 2'd2;

    typedef struct packed {
        logic signed [DW-1:0] re;
        logic signed [DW-1:0] im;
    } t_cplx;

    typedef struct packed {
        logic       res;    // item gives a result
        logic       vw;     // vector write
        logic [1:0] mode;
        logic [2:0] kern;
        logic [4:0] orow;
        logic [4:0] ocol;
    } t_ctl;

    localparam logic signed [39:0] SAT_HI = 40'sd2147483647;
    localparam logic signed [39:0] SAT_LO = -40'sd2147483648;

    function automatic logic signed [DW-1:0] sat32(input logic signed [39:0] x);
        logic signed [DW-1:0] r;
        if (x > SAT_HI) begin
            r = SAT_HI[DW-1:0];
        end else if (x < SAT_LO) begin
            r = SAT_LO[DW-1:0];
        end else begin
            r = x[DW-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/bttu_if.sv =====
// Handshake channels of the butterfly tile transform: input, result, config.
// Depends on bttu_pkg.
interface bttu_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [1:0]  tile_sel;
    logic [4:0]  row;
    logic [4:0]  col;
    logic [11:0] vec_addr;
    logic signed [31:0] value_re;
    logic signed [31:0] value_im;
    modport source (output valid, func, tile_sel, row, col, vec_addr, value_re, value_im,
                    input ready);
    modport sink   (input valid, func, tile_sel, row, col, vec_addr, value_re, value_im,
                    output ready);
endinterface

interface bttu_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  out_row;
    logic [4:0]  out_col;
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    modport source (output valid, out_row, out_col, res_re, res_im, input ready);
    modport sink   (input valid, out_row, out_col, res_re, res_im, output ready);
endinterface

interface bttu_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [12:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/butterfly_tile_transform_unit.sv =====
// Top level of the butterfly tile transform: tile and vector memories, pipeline.
// Depends on bttu_pkg, bttu_if, bttu_vmod, bttu_cmul, assert_macros.svh.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+----------------------------------------------
//  i_in     | in  | valid/ready   | func tile_sel row col vec_addr value_re/im
//  o_out    | out | valid/ready   | out_row out_col res_re res_im
//  i_cfg    | in  | valid/ready   | index data (ready always high)
//
// One request enters per cycle while the pipe is not held by o_out.ready; a result
// leaves after the tile memory read, the vector address wrap stages, the vector
// memory read, the stages of each multiplier pass and the output register.
// Synchronous active-low reset clears the stage valid bits and the configuration
// registers; memories are not cleared and need no clearing pass.
// Each stage moves when the one after it is empty or moving, so bubbles close
// up and, while a stage is empty, requests are still taken as a result waits at the output.
`include "assert_macros.svh"

module butterfly_tile_transform_unit #(
    parameter int TILE      = 32,
    parameter int VEC_DEPTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bttu_in_if.sink     i_in,
    bttu_out_if.source  o_out,
    bttu_cfg_if.sink    i_cfg
);
    import bttu_pkg::*;

    localparam int TW    = $clog2(TILE);
    localparam int AREA  = TILE * TILE;
    localparam int AW    = $clog2(AREA);
    localparam int VAW   = $clog2(VEC_DEPTH);
    localparam int NS    = 9;

    // ---------------- configuration ----------------
    logic [2:0]  r_kernel, r_level;
    logic [12:0] r_size_n;
    logic [11:0] r_row_seg, r_col_seg;
    logic        r_herm, r_diag, r_conj;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel  <= K_TL;
            r_level   <= '0;
            r_size_n  <= 13'd2;
            r_row_seg <= '0;
            r_col_seg <= '0;
            r_herm    <= 1'b0;
            r_diag    <= 1'b0;
            r_conj    <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                R_KERNEL: r_kernel  <= i_cfg.data[2:0];
                R_LEVEL:  r_level   <= i_cfg.data[2:0];
                R_SIZE_N: r_size_n  <= i_cfg.data;
                R_ROWSEG: r_row_seg <= i_cfg.data[11:0];
                R_COLSEG: r_col_seg <= i_cfg.data[11:0];
                R_HERM:   r_herm    <= i_cfg.data[0];
                R_DIAG:   r_diag    <= i_cfg.data[0];
                R_CONJ:   r_conj    <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // ---------------- stage enables ----------------
    logic [NS:1] r_vld, en;
    logic        accept;

    always_comb begin
        en[NS] = !r_vld[NS] || o_out.ready;
        for (int k = NS - 1; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign i_in.ready = en[1];
    assign accept     = i_in.valid && en[1];

    // ---------------- request decode ----------------
    logic [TW-1:0] row_m, col_m;
    logic [AW-1:0] addr_n, addr_h;
    logic [15:0]   base_lv;
    logic [11:0]   half;
    logic [XW-1:0] xl, xr, base_r, base_c;
    logic          two, one, res;
    t_ctl          ctl;
    t_cplx         wval;

    // row and col wrap to the tile size
    always_comb begin
        row_m = '0;
        col_m = '0;
        for (int k = 0; k < 32; k++) begin
            if (i_in.row == 5'(k)) row_m = TW'(k % TILE);
            if (i_in.col == 5'(k)) col_m = TW'(k % TILE);
        end
    end

    assign addr_n = AW'(col_m) * AW'(TILE) + AW'(row_m);
    assign addr_h = AW'(row_m) * AW'(TILE) + AW'(col_m);   // hermitian: tr(col,row)

    assign base_lv = 16'(r_level) * 16'(r_size_n);
    assign half    = r_size_n[12:1];
    assign base_r  = XW'(base_lv) + XW'(r_row_seg);
    assign base_c  = XW'(base_lv) + XW'(r_col_seg);

    assign two = (r_kernel <= K_BR);
    assign one = (r_kernel == K_TOP) || (r_kernel == K_BTM);
    // diagonal tile drops the upper triangle for TL and BR
    assign res = (i_in.func == F_COMP) && (two || one) &&
                 !(r_diag && (r_kernel == K_TL || r_kernel == K_BR) && i_in.row < i_in.col);

    always_comb begin
        xl = base_r + XW'(i_in.row);
        xr = base_c + XW'(i_in.col);
        if (i_in.func == F_WR_VEC) begin
            xl = XW'(i_in.vec_addr);
        end else if (two) begin
            if (r_kernel == K_BL || r_kernel == K_BR) xl = xl + XW'(half);
            if (r_kernel >= K_TR) xr = xr + XW'(half);
        end else begin
            // one-sided: r on the left port, s on the right port;
            // transposed bottom multiplies by s, so it goes on the left too
            xr = base_r + XW'(i_in.row) + XW'(half);
            if (r_conj && r_kernel == K_BTM) xl = xl + XW'(half);
        end
    end

    always_comb begin
        ctl.res  = res;
        ctl.vw   = (i_in.func == F_WR_VEC);
        ctl.mode = two ? M_TWO : (r_conj ? M_TRANS : M_PLAIN);
        ctl.kern = r_kernel;
        ctl.orow = (r_kernel == K_TRT) ? i_in.col : i_in.row;
        ctl.ocol = (r_kernel == K_TRT) ? i_in.row : i_in.col;
    end

    assign wval.re = i_in.value_re;
    assign wval.im = i_in.value_im;

    // ---------------- tile memories (read at accept) ----------------
    t_cplx r_t1 [NTILE];

    for (genvar t = 0; t < NTILE; t++) begin : g_tile
        t_cplx mem [AREA];
        logic [AW-1:0] raddr;
        assign raddr = (t == 2 && r_herm) ? addr_h : addr_n;
        always_ff @(posedge i_clk) begin
            if (accept && i_in.func == F_WR_TILE && i_in.tile_sel == 2'(t)) begin
                mem[addr_n] <= wval;
            end
            if (en[1]) begin
                r_t1[t] <= mem[raddr];
            end
        end
    end

    // ---------------- stage 1 ----------------
    t_ctl          r_c1;
    logic [XW-1:0] r_xl1, r_xr1;
    t_cplx         r_vd1;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_c1  <= ctl;
            r_xl1 <= xl;
            r_xr1 <= xr;
            r_vd1 <= wval;
        end
    end

    // four-tile combine (two-sided) or top +/- bottom (transposed), exact then saturated; plain passes tile 0
    logic signed [34:0] pa_re, pa_im, pb_re, pb_im, sm_re, sm_im;
    logic               plus_pair, outer_add;
    t_cplx              b1;

    assign plus_pair = (r_c1.kern == K_TL) || (r_c1.kern == K_TR) || (r_c1.kern == K_TRT);
    assign outer_add = (r_c1.kern == K_TL) || (r_c1.kern == K_BL);

    always_comb begin
        if (r_c1.mode == M_TWO) begin
            pa_re = plus_pair ? 35'(r_t1[0].re) + 35'(r_t1[1].re) : 35'(r_t1[0].re) - 35'(r_t1[1].re);
            pa_im = plus_pair ? 35'(r_t1[0].im) + 35'(r_t1[1].im) : 35'(r_t1[0].im) - 35'(r_t1[1].im);
            pb_re = plus_pair ? 35'(r_t1[2].re) + 35'(r_t1[3].re) : 35'(r_t1[2].re) - 35'(r_t1[3].re);
            pb_im = plus_pair ? 35'(r_t1[2].im) + 35'(r_t1[3].im) : 35'(r_t1[2].im) - 35'(r_t1[3].im);
        end else begin
            // one-sided: top +/- bottom
            pa_re = (r_c1.kern == K_TOP) ? 35'(r_t1[0].re) + 35'(r_t1[1].re)
                                         : 35'(r_t1[0].re) - 35'(r_t1[1].re);
            pa_im = (r_c1.kern == K_TOP) ? 35'(r_t1[0].im) + 35'(r_t1[1].im)
                                         : 35'(r_t1[0].im) - 35'(r_t1[1].im);
            pb_re = '0;
            pb_im = '0;
        end
        sm_re = (r_c1.mode != M_TWO || outer_add) ? pa_re + pb_re : pa_re - pb_re;
        sm_im = (r_c1.mode != M_TWO || outer_add) ? pa_im + pb_im : pa_im - pb_im;
        if (r_c1.mode == M_PLAIN) begin
            b1 = r_t1[0];
        end else begin
            b1.re = sat32(40'(sm_re));
            b1.im = sat32(40'(sm_im));
        end
    end

    // ---------------- stages 2 and 3 ----------------
    t_ctl           r_c2, r_c3;
    t_cplx          r_b2, r_b3, r_bl2, r_bl3, r_vd2, r_vd3;
    logic [VAW-1:0] al3, ar3;

    bttu_vmod #(.VEC_DEPTH(VEC_DEPTH)) u_vmod (
        .i_clk  (i_clk),
        .i_en_q (en[2]),
        .i_en_r (en[3]),
        .i_xl   (r_xl1),
        .i_xr   (r_xr1),
        .o_al   (al3),
        .o_ar   (ar3)
    );

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_c2  <= r_c1;
            r_b2  <= b1;
            r_bl2 <= r_t1[1];
            r_vd2 <= r_vd1;
        end
        if (en[3]) begin
            r_c3  <= r_c2;
            r_b3  <= r_b2;
            r_bl3 <= r_bl2;
            r_vd3 <= r_vd2;
        end
    end

    // ---------------- vector memory, two read copies ----------------
    // Vector writes take effect in stage order, so later requests see them.
    t_cplx vmem_l [VEC_DEPTH];
    t_cplx vmem_r [VEC_DEPTH];
    t_cplx r_vl4, r_vr4;
    logic  vec_we;

    assign vec_we = r_vld[3] && r_c3.vw && en[4];

    always_ff @(posedge i_clk) begin
        if (vec_we) vmem_l[al3] <= r_vd3;
        if (en[4])  r_vl4 <= vmem_l[al3];
    end

    always_ff @(posedge i_clk) begin
        if (vec_we) vmem_r[al3] <= r_vd3;
        if (en[4])  r_vr4 <= vmem_r[ar3];
    end

    // ---------------- stages 4 to 6: first product ----------------
    t_ctl  r_c4, r_c5, r_c6;
    t_cplx r_b4, r_bl4, r_bl5, r_bl6, r_vr5, r_vr6;
    logic signed [37:0] m1_re, m1_im;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_c4  <= r_c3;
            r_b4  <= r_b3;
            r_bl4 <= r_bl3;
        end
        if (en[5]) begin
            r_c5  <= r_c4;
            r_bl5 <= r_bl4;
            r_vr5 <= r_vr4;
        end
        if (en[6]) begin
            r_c6  <= r_c5;
            r_bl6 <= r_bl5;
            r_vr6 <= r_vr5;
        end
    end

    bttu_cmul u_mul1 (
        .i_clk  (i_clk),
        .i_en_p (en[5]),
        .i_en_r (en[6]),
        .i_a    (r_vl4),
        .i_b    (r_b4),
        .o_re   (m1_re),
        .o_im   (m1_im)
    );

    // ---------------- stages 7 and 8: second product ----------------
    t_cplx a2, b2;
    t_ctl  r_c7, r_c8;
    logic signed [37:0] r_m1re7, r_m1im7, r_m1re8, r_m1im8, m2_re, m2_im;

    always_comb begin
        if (r_c6.mode == M_TWO) begin
            a2.re = sat32(40'(m1_re));
            a2.im = sat32(40'(m1_im));
            b2    = r_vr6;
        end else begin
            a2 = r_vr6;     // s
            b2 = r_bl6;     // bottom
        end
    end

    bttu_cmul u_mul2 (
        .i_clk  (i_clk),
        .i_en_p (en[7]),
        .i_en_r (en[8]),
        .i_a    (a2),
        .i_b    (b2),
        .o_re   (m2_re),
        .o_im   (m2_im)
    );

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r_c7    <= r_c6;
            r_m1re7 <= m1_re;
            r_m1im7 <= m1_im;
        end
        if (en[8]) begin
            r_c8    <= r_c7;
            r_m1re8 <= r_m1re7;
            r_m1im8 <= r_m1im7;
        end
    end

    // ---------------- final combine and output register ----------------
    logic signed [38:0] fin_re, fin_im;
    logic [4:0]         r_orow, r_ocol;
    logic signed [31:0] r_ore, r_oim;

    always_comb begin
        case (r_c8.mode)
            M_TWO: begin
                fin_re = 39'(m2_re);
                fin_im = 39'(m2_im);
            end
            M_TRANS: begin
                fin_re = 39'(r_m1re8);
                fin_im = 39'(r_m1im8);
            end
            default: begin
                // plain: r*top +/- s*bottom, saturated once
                fin_re = (r_c8.kern == K_TOP) ? 39'(r_m1re8) + 39'(m2_re)
                                              : 39'(r_m1re8) - 39'(m2_re);
                fin_im = (r_c8.kern == K_TOP) ? 39'(r_m1im8) + 39'(m2_im)
                                              : 39'(r_m1im8) - 39'(m2_im);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[9]) begin
            r_orow <= r_c8.orow;
            r_ocol <= r_c8.ocol;
            r_ore  <= sat32(40'(fin_re));
            r_oim  <= sat32(40'(fin_im));
        end
    end

    // ---------------- stage valids ----------------
    // Write requests leave the pipe after the vector write stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) r_vld[1] <= i_in.valid;
            if (en[2]) r_vld[2] <= r_vld[1];
            if (en[3]) r_vld[3] <= r_vld[2];
            if (en[4]) r_vld[4] <= r_vld[3] && r_c3.res;
            for (int k = 5; k <= NS; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign o_out.valid   = r_vld[NS];
    assign o_out.out_row = r_orow;
    assign o_out.out_col = r_ocol;
    assign o_out.res_re  = r_ore;
    assign o_out.res_im  = r_oim;

    // ---------------- checks ----------------
    `BTTU_ASSERT_ALWAYS(a_rst_clears, !i_rst_n |=> (r_vld == '0), "valids not cleared by reset")
    `BTTU_ASSERT(a_accept_loads, accept |=> r_vld[1], "accepted request lost at stage 1")
    `BTTU_ASSERT(a_only_results, r_vld[4] |-> r_c4.res, "non-result request past vector stage")
    `BTTU_ASSERT(a_stall_holds, (r_vld[4] && !en[5]) |=> r_vld[4], "stalled stage 4 dropped item")
endmodule

// ===== rtl/core/bttu_cmul.sv =====
// Two-stage complex multiplier: registered products, then rounding and combine.
// Depends on bttu_pkg.
module bttu_cmul (
    input  logic             i_clk,
    input  logic             i_en_p,
    input  logic             i_en_r,
    input  bttu_pkg::t_cplx  i_a,
    input  bttu_pkg::t_cplx  i_b,
    output logic signed [37:0] o_re,
    output logic signed [37:0] o_im
);
    import bttu_pkg::*;

    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC - 1);

    logic signed [63:0] r_p [4];
    logic signed [36:0] rnd [4];
    logic signed [37:0] r_re, r_im;

    always_ff @(posedge i_clk) begin
        if (i_en_p) begin
            r_p[0] <= i_a.re * i_b.re;
            r_p[1] <= i_a.im * i_b.im;
            r_p[2] <= i_a.re * i_b.im;
            r_p[3] <= i_a.im * i_b.re;
        end
    end

    // floor((p + 2^26) / 2^27)
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            rnd[k] = 37'((r_p[k] + HALF) >>> FRAC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_r) begin
            r_re <= 38'(rnd[0]) - 38'(rnd[1]);
            r_im <= 38'(rnd[2]) + 38'(rnd[3]);
        end
    end

    assign o_re = r_re;
    assign o_im = r_im;
endmodule

// ===== rtl/core/bttu_vmod.sv =====
// Vector address wrap: x mod VEC_DEPTH by reciprocal multiply, two stages.
// Depends on bttu_pkg.
module bttu_vmod #(
    parameter int VEC_DEPTH = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_en_q,
    input  logic                          i_en_r,
    input  logic [bttu_pkg::XW-1:0]       i_xl,
    input  logic [bttu_pkg::XW-1:0]       i_xr,
    output logic [$clog2(VEC_DEPTH)-1:0]  o_al,
    output logic [$clog2(VEC_DEPTH)-1:0]  o_ar
);
    import bttu_pkg::*;

    localparam int VAW = $clog2(VEC_DEPTH);
    localparam int SH  = 34;   // exact quotient for x < 2^17
    localparam logic [34:0] MAGIC = 35'(((64'd1 << SH) / VEC_DEPTH) + 64'd1);

    logic [XW-1:0] r_xl, r_xr, r_ql, r_qr;
    logic [XW-1:0] rem_l, rem_r;
    logic [VAW-1:0] r_al, r_ar;

    always_ff @(posedge i_clk) begin
        if (i_en_q) begin
            r_xl <= i_xl;
            r_xr <= i_xr;
            r_ql <= XW'((52'(i_xl) * 52'(MAGIC)) >> SH);
            r_qr <= XW'((52'(i_xr) * 52'(MAGIC)) >> SH);
        end
    end

    assign rem_l = r_xl - XW'(r_ql * XW'(VEC_DEPTH));
    assign rem_r = r_xr - XW'(r_qr * XW'(VEC_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_en_r) begin
            r_al <= VAW'(rem_l);
            r_ar <= VAW'(rem_r);
        end
    end

    assign o_al = r_al;
    assign o_ar = r_ar;
endmodule
